// ----- hdl/rti_pkg.sv -----
// Shared types and constants of the regression tree inference block.
package rti_pkg;

	localparam logic [16:0] WEIGHT_ONE       = 17'd65536;
	localparam logic [9:0]  STEP_LIMIT_RESET = 10'd1000;

	typedef enum logic [1:0] {
		OP_NODE    = 2'd0,
		OP_FEATURE = 2'd1,
		OP_EVAL    = 2'd2
	} op_t;

	typedef enum logic {
		REG_WEIGHTED   = 1'b0,
		REG_STEP_LIMIT = 1'b1
	} reg_idx_t;

	typedef struct packed {
		logic               is_leaf;
		logic [4:0]         feat;
		logic signed [31:0] threshold;
		logic [9:0]         left;
		logic [9:0]         right;
		logic signed [31:0] mean;
		logic [16:0]        weight;
	} node_t;

	typedef struct packed {
		logic               missing;
		logic signed [31:0] value;
	} feature_t;

	typedef struct packed {
		logic mul_en;
		logic fin_en;
		logic weighted;
	} alu_ctl_t;

endpackage

// ----- hdl/rti_ram.sv -----
// Generic single-port-write, single-port-read RAM with registered read data.
module rti_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                                     clk,
	input  logic                                     we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                         wdata,
	input  logic                                     re,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// ----- hdl/rti_alu.sv -----
// Step arithmetic: weighted blend over two stages and saturating contribution update.
module rti_alu import rti_pkg::*; (
	input  logic               clk,
	input  alu_ctl_t           ctl,
	input  logic signed [31:0] mean,
	input  logic [16:0]        weight,
	input  logic signed [31:0] run,
	input  logic signed [31:0] old_sum,
	output logic signed [31:0] next_run,
	output logic signed [31:0] next_sum
);

	logic [16:0]        w_sat;
	logic signed [32:0] diff;
	logic signed [50:0] prod;
	logic signed [50:0] prod_s1;
	logic signed [31:0] mean_s1;
	logic signed [51:0] acc;
	logic signed [31:0] blend;
	logic signed [31:0] run_s2;
	logic signed [33:0] sum;

	// run + (mean - run) * w, one multiply
	always_comb begin
		w_sat = (weight > WEIGHT_ONE) ? WEIGHT_ONE : weight;
		diff  = {mean[31], mean} - {run[31], run};
		prod  = diff * $signed({1'b0, w_sat});
	end

	always_ff @(posedge clk) begin
		if (ctl.mul_en) begin
			prod_s1 <= prod;
			mean_s1 <= mean;
		end
	end

	// round half up, then floor shift
	always_comb begin
		acc   = (52'(run) <<< 16) + 52'(prod_s1) + 52'sd32768;
		blend = acc[47:16];
	end

	always_ff @(posedge clk) begin
		if (ctl.fin_en) begin
			run_s2 <= ctl.weighted ? blend : mean_s1;
		end
	end

	always_comb begin
		sum = 34'(run_s2) - 34'(run) + 34'(old_sum);
		if (sum > 34'sd2147483647) begin
			next_sum = 32'sh7fffffff;
		end else if (sum < -34'sd2147483648) begin
			next_sum = 32'sh80000000;
		end else begin
			next_sum = sum[31:0];
		end
	end

	assign next_run = run_s2;

endmodule

// ----- hdl/regression_tree_inference.sv -----
// Top level of the regression tree inference block: sequencer, stores and result register.
//
//   channel   | handshake                   | payload
//   ----------+-----------------------------+--------------------------------------------
//   item      | item_valid / item_stall     | op, address, node fields, feature fields
//   result    | result_valid / result_stall | value, feature_index, is_prediction, last
//   config    | cfg_write                   | cfg_index, cfg_data
//
// A load item is written into its store as it is accepted. An evaluate item walks from
// the root: each descent reads the node memory, runs the two-stage blend and does the
// read-modify-write of one contribution sum. The root fetch and the final test come
// before emission, plus the feature read when the walk stops on a missing feature or
// on a child outside the node store; then the prediction and one contribution per cycle, unless stalled.
// Reset is asynchronous and clears the sequencer, the registers and the sum valid bits;
// the memories are not cleared. A stall on the result side holds the result register
// and pauses emission; the next item is accepted once the last result is loaded.
module regression_tree_inference import rti_pkg::*; #(
	parameter int NODES    = 1024,
	parameter int FEATURES = 32
) (
	input  logic               clk,
	input  logic               arst_n,
	// item channel
	input  logic               item_valid,
	output logic               item_stall,
	input  logic [1:0]         op,
	input  logic [9:0]         address,
	input  logic [4:0]         split_feature,
	input  logic signed [31:0] threshold,
	input  logic [9:0]         left_child,
	input  logic [9:0]         right_child,
	input  logic signed [31:0] node_mean,
	input  logic [16:0]        node_weight,
	input  logic               is_leaf,
	input  logic signed [31:0] feature_value,
	input  logic               feature_missing,
	// result channel
	output logic               result_valid,
	input  logic               result_stall,
	output logic signed [31:0] value,
	output logic [4:0]         feature_index,
	output logic               is_prediction,
	output logic               last,
	// configuration
	input  logic               cfg_write,
	input  logic               cfg_index,
	input  logic [9:0]         cfg_data
);

	localparam int NW = $clog2(NODES);
	localparam int FW = (FEATURES > 1) ? $clog2(FEATURES) : 1;
	localparam int NODE_BITS = $bits(node_t);
	localparam int FEAT_BITS = $bits(feature_t);

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_ROOT,
		ST_TEST,
		ST_FEAT,
		ST_DESC,
		ST_FIN,
		ST_WB,
		ST_PRED,
		ST_CONTRIB
	} state_t;

	state_t             state_q;

	// configuration registers
	logic               weighted_q;
	logic [9:0]         step_limit_q;

	// walk context
	node_t              node_q;
	logic [4:0]         feat_q;
	logic signed [31:0] run_q;
	logic [9:0]         count_q;
	logic [9:0]         limit_q;
	logic [FEATURES-1:0] c_vld_q;
	logic [FW-1:0]      emit_idx_q;

	// result register
	logic               out_valid_q;
	logic signed [31:0] out_value_q;
	logic [4:0]         out_fidx_q;
	logic               out_pred_q;
	logic               out_last_q;

	// memory ports
	logic               n_we, n_re;
	logic [NW-1:0]      n_waddr, n_raddr;
	node_t              n_wdata, n_rdata;
	logic               f_we, f_re;
	logic [FW-1:0]      f_waddr, f_raddr;
	feature_t           f_wdata, f_rdata;
	logic               c_we, c_re;
	logic [FW-1:0]      c_waddr, c_raddr;
	logic signed [31:0] c_wdata, c_rdata;

	// step arithmetic
	alu_ctl_t           alu_ctl;
	logic signed [31:0] next_run, next_sum, old_sum;

	logic               accept;
	logic               out_free;
	logic               out_load;
	logic               test_stop;
	logic [9:0]         child;
	logic               go_down;
	logic [FW-1:0]      feat_fw;
	logic               emit_last;
	logic signed [31:0] emit_val;

	assign accept     = item_valid && !item_stall;
	assign out_free   = !out_valid_q || !result_stall;
	assign out_load   = out_free && ((state_q == ST_PRED) || (state_q == ST_CONTRIB));
	assign feat_fw    = FW'(feat_q);
	assign emit_last  = (emit_idx_q == FW'(FEATURES - 1));
	assign old_sum    = c_vld_q[feat_fw] ? c_rdata : 32'sd0;
	assign emit_val   = c_vld_q[emit_idx_q] ? c_rdata : 32'sd0;

	// stop on leaf, step limit or a split feature outside the store
	assign test_stop = (count_q >= limit_q) || node_q.is_leaf ||
		(6'(node_q.feat) >= 6'(FEATURES));

	// greater goes right; a child outside the store ends the walk here
	assign child   = (f_rdata.value > node_q.threshold) ? node_q.right : node_q.left;
	assign go_down = !f_rdata.missing && (17'(child) < 17'(NODES));

	always_comb begin
		item_stall = (state_q != ST_IDLE);
	end

	// memory and arithmetic control
	always_comb begin
		n_we    = 1'b0;
		n_re    = 1'b0;
		n_waddr = NW'(address);
		n_raddr = '0;
		n_wdata = '{is_leaf: is_leaf, feat: split_feature, threshold: threshold,
			left: left_child, right: right_child, mean: node_mean, weight: node_weight};
		f_we    = 1'b0;
		f_re    = 1'b0;
		f_waddr = FW'(address);
		f_raddr = FW'(node_q.feat);
		f_wdata = '{missing: feature_missing, value: feature_value};
		c_we    = 1'b0;
		c_re    = 1'b0;
		c_waddr = feat_fw;
		c_raddr = '0;
		c_wdata = next_sum;
		alu_ctl = '{mul_en: 1'b0, fin_en: 1'b0, weighted: weighted_q};
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					case (op)
						OP_NODE:    n_we = (17'(address) < 17'(NODES));
						OP_FEATURE: f_we = (address < 10'(FEATURES));
						OP_EVAL:    n_re = 1'b1;
						default:    ;
					endcase
				end
			end
			ST_TEST: f_re = !test_stop;
			ST_FEAT: begin
				n_re    = go_down;
				n_raddr = NW'(child);
				c_re    = go_down;
				c_raddr = feat_fw;
			end
			ST_DESC: alu_ctl.mul_en = 1'b1;
			ST_FIN:  alu_ctl.fin_en = 1'b1;
			ST_WB:   c_we = 1'b1;
			ST_PRED: c_re = out_free;
			ST_CONTRIB: begin
				c_re    = out_free && !emit_last;
				c_raddr = FW'(emit_idx_q + 1'b1);
			end
			default: ;
		endcase
	end

	// configuration registers; the user must write them only while idle, the block does not enforce it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			weighted_q   <= 1'b0;
			step_limit_q <= STEP_LIMIT_RESET;
		end else if (cfg_write) begin
			case (cfg_index)
				REG_WEIGHTED:   weighted_q   <= cfg_data[0];
				REG_STEP_LIMIT: step_limit_q <= cfg_data;
				default:        ;
			endcase
		end
	end

	// sequencer and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			node_q      <= '0;
			feat_q      <= '0;
			run_q       <= '0;
			count_q     <= '0;
			limit_q     <= '0;
			c_vld_q     <= '0;
			emit_idx_q  <= '0;
			out_valid_q <= 1'b0;
			out_value_q <= '0;
			out_fidx_q  <= '0;
			out_pred_q  <= 1'b0;
			out_last_q  <= 1'b0;
		end else begin
			// drop the result once taken unless a new one loads below
			if (out_valid_q && !result_stall && !out_load) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (accept && op == OP_EVAL) begin
						c_vld_q <= '0;
						count_q <= '0;
						if (weighted_q) begin
							limit_q <= (step_limit_q == 10'd0) ? 10'd0 : step_limit_q - 10'd1;
						end else begin
							limit_q <= step_limit_q;
						end
						state_q <= ST_ROOT;
					end
				end
				ST_ROOT: begin
					node_q  <= n_rdata;
					run_q   <= n_rdata.mean;
					state_q <= ST_TEST;
				end
				ST_TEST: begin
					feat_q  <= node_q.feat;
					state_q <= test_stop ? ST_PRED : ST_FEAT;
				end
				ST_FEAT: begin
					state_q <= go_down ? ST_DESC : ST_PRED;
				end
				ST_DESC: begin
					node_q  <= n_rdata;
					state_q <= ST_FIN;
				end
				ST_FIN: begin
					state_q <= ST_WB;
				end
				ST_WB: begin
					// the sum write lands before the next read of any sum
					run_q            <= next_run;
					count_q          <= count_q + 10'd1;
					c_vld_q[feat_fw] <= 1'b1;
					state_q          <= ST_TEST;
				end
				ST_PRED: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						out_value_q <= run_q;
						out_fidx_q  <= '0;
						out_pred_q  <= 1'b1;
						out_last_q  <= 1'b0;
						emit_idx_q  <= '0;
						state_q     <= ST_CONTRIB;
					end
				end
				ST_CONTRIB: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						out_value_q <= emit_val;
						out_fidx_q  <= 5'(emit_idx_q);
						out_pred_q  <= 1'b0;
						out_last_q  <= emit_last;
						if (emit_last) begin
							state_q <= ST_IDLE;
						end else begin
							emit_idx_q <= emit_idx_q + 1'b1;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign result_valid  = out_valid_q;
	assign value         = out_value_q;
	assign feature_index = out_fidx_q;
	assign is_prediction = out_pred_q;
	assign last          = out_last_q;

	rti_ram #(.WIDTH(NODE_BITS), .DEPTH(NODES)) u_node_ram (
		.clk   (clk),
		.we    (n_we),
		.waddr (n_waddr),
		.wdata (n_wdata),
		.re    (n_re),
		.raddr (n_raddr),
		.rdata (n_rdata)
	);

	rti_ram #(.WIDTH(FEAT_BITS), .DEPTH(FEATURES)) u_feat_ram (
		.clk   (clk),
		.we    (f_we),
		.waddr (f_waddr),
		.wdata (f_wdata),
		.re    (f_re),
		.raddr (f_raddr),
		.rdata (f_rdata)
	);

	rti_ram #(.WIDTH(32), .DEPTH(FEATURES)) u_sum_ram (
		.clk   (clk),
		.we    (c_we),
		.waddr (c_waddr),
		.wdata (c_wdata),
		.re    (c_re),
		.raddr (c_raddr),
		.rdata (c_rdata)
	);

	rti_alu u_alu (
		.clk      (clk),
		.ctl      (alu_ctl),
		.mean     (n_rdata.mean),
		.weight   (n_rdata.weight),
		.run      (run_q),
		.old_sum  (old_sum),
		.next_run (next_run),
		.next_sum (next_sum)
	);

endmodule

// ----- hdl/rti_checker.sv -----
// Port-level checks of the regression tree inference block, bound to the top level.
module rti_checker import rti_pkg::*; (
	input logic               clk,
	input logic               arst_n,
	input logic               item_valid,
	input logic               item_stall,
	input logic [1:0]         op,
	input logic               result_valid,
	input logic               result_stall,
	input logic signed [31:0] value,
	input logic [4:0]         feature_index,
	input logic               is_prediction,
	input logic               last
);

	logic res_xfer;
	logic eval_xfer;

	assign res_xfer  = result_valid && !result_stall;
	assign eval_xfer = item_valid && !item_stall && (op == OP_EVAL);

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_stall |=> result_valid && $stable(value) &&
			$stable(feature_index) && $stable(is_prediction) && $stable(last))
		else $error("stalled result changed");

	a_pred_fields: assert property (@(posedge clk) disable iff (!arst_n)
		res_xfer && is_prediction |-> (feature_index == 5'd0) && !last)
		else $error("prediction with feature index or last mark");

	a_pred_busy: assert property (@(posedge clk) disable iff (!arst_n)
		res_xfer && is_prediction |-> item_stall)
		else $error("item taken while contributions pending");

	a_pred_next: assert property (@(posedge clk) disable iff (!arst_n)
		res_xfer && is_prediction |=> result_valid && !is_prediction)
		else $error("no contribution right after prediction");

	a_eval_busy: assert property (@(posedge clk) disable iff (!arst_n)
		eval_xfer |=> item_stall)
		else $error("item taken during evaluation");

endmodule

bind regression_tree_inference rti_checker u_rti_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.item_valid    (item_valid),
	.item_stall    (item_stall),
	.op            (op),
	.result_valid  (result_valid),
	.result_stall  (result_stall),
	.value         (value),
	.feature_index (feature_index),
	.is_prediction (is_prediction),
	.last          (last)
);

// ----- tb/sv/tb.sv -----
// Testbench for the regression tree inference block: directed and random trees.
`timescale 1ns / 100ps

module tb;
	import rti_pkg::*;

	localparam int NODES       = 1024;
	localparam int FEATURES    = 32;
	localparam int RANDOM_ITEMS = 64;
	// Cycles to let a trailing load finish before touching the registers.
	localparam int SETTLE_CYCLES = 8;
	localparam longint TIMEOUT_NS = 20_000_000;

	localparam logic [1:0]         OP_UNUSED = 2'd3;
	localparam logic signed [31:0] Q_MAX     = 32'sh7FFF_FFFF;
	localparam logic signed [31:0] Q_MIN     = 32'sh8000_0000;
	localparam longint             ONE_Q     = 65536;
	localparam longint             SUM_MAX   = 64'sd2147483647;
	localparam longint             SUM_MIN   = -64'sd2147483648;

	typedef struct {
		logic [1:0]         op;
		logic [9:0]         address;
		logic [4:0]         split_feature;
		logic signed [31:0] threshold;
		logic [9:0]         left_child;
		logic [9:0]         right_child;
		logic signed [31:0] node_mean;
		logic [16:0]        node_weight;
		logic               is_leaf;
		logic signed [31:0] feature_value;
		logic               feature_missing;
	} item_t;

	typedef struct {
		logic signed [31:0] value;
		logic [4:0]         feature_index;
		logic               is_prediction;
		logic               last;
	} result_t;

	// DUT inputs start at known values before the first edge.
	logic               clk             = 1'b0;
	logic               arst_n          = 1'b0;
	logic               item_valid      = 1'b0;
	logic [1:0]         op              = OP_NODE;
	logic [9:0]         address         = '0;
	logic [4:0]         split_feature   = '0;
	logic signed [31:0] threshold       = '0;
	logic [9:0]         left_child      = '0;
	logic [9:0]         right_child     = '0;
	logic signed [31:0] node_mean       = '0;
	logic [16:0]        node_weight     = '0;
	logic               is_leaf         = 1'b0;
	logic signed [31:0] feature_value   = '0;
	logic               feature_missing = 1'b0;
	logic               result_stall    = 1'b0;
	logic               cfg_write       = 1'b0;
	logic               cfg_index       = REG_WEIGHTED;
	logic [9:0]         cfg_data        = '0;

	logic               item_stall;
	logic               result_valid;
	logic signed [31:0] value;
	logic [4:0]         feature_index;
	logic               is_prediction;
	logic               last;

	// Predictor copy of the stores and registers.
	node_t       node_mem [NODES];
	feature_t    feat_mem [FEATURES];
	bit          feature_known [FEATURES];
	bit          weighted_cfg = 1'b0;
	logic [9:0]  limit_cfg    = STEP_LIMIT_RESET;

	result_t     outputs_due [$];
	logic [9:0]  tree_slots [$];

	int unsigned burst_left      = 0;
	int unsigned useful_items    = 0;
	int unsigned evaluations     = 0;
	int unsigned node_writes     = 0;
	int unsigned feature_writes  = 0;
	int unsigned config_writes   = 0;
	int unsigned results_checked = 0;
	int unsigned mismatches      = 0;

	regression_tree_inference u_top (
		.clk             (clk),
		.arst_n          (arst_n),
		.item_valid      (item_valid),
		.item_stall      (item_stall),
		.op              (op),
		.address         (address),
		.split_feature   (split_feature),
		.threshold       (threshold),
		.left_child      (left_child),
		.right_child     (right_child),
		.node_mean       (node_mean),
		.node_weight     (node_weight),
		.is_leaf         (is_leaf),
		.feature_value   (feature_value),
		.feature_missing (feature_missing),
		.result_valid    (result_valid),
		.result_stall    (result_stall),
		.value           (value),
		.feature_index   (feature_index),
		.is_prediction   (is_prediction),
		.last            (last),
		.cfg_write       (cfg_write),
		.cfg_index       (cfg_index),
		.cfg_data        (cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Walk the tree from the root as the block does and queue the prediction
	// followed by one contribution per feature.
	function automatic void walk_tree();
		int unsigned node;
		int unsigned steps;
		int unsigned bound;
		longint      run;
		longint      prev;
		longint      mean_v;
		longint      w;
		longint      blend_sum;
		longint      acc;
		longint      sums [FEATURES];
		node_t       nd;
		feature_t    fv;
		logic [9:0]  child;
		result_t     r;

		foreach (sums[f])
			sums[f] = 0;
		// Weighted mode allows one descent fewer than the step limit.
		if (weighted_cfg)
			bound = (limit_cfg == 0) ? 0 : limit_cfg - 1;
		else
			bound = limit_cfg;
		node  = 0;
		steps = 0;
		run   = $signed(node_mem[0].mean);
		prev  = run;
		while (steps < bound) begin
			nd = node_mem[node];
			if (nd.is_leaf)
				break;
			if (nd.feat >= FEATURES)
				break;
			fv = feat_mem[nd.feat];
			if (fv.missing)
				break;
			child = ($signed(fv.value) > $signed(nd.threshold)) ? nd.right : nd.left;
			if (child >= NODES)
				break;
			node   = child;
			mean_v = $signed(node_mem[node].mean);
			if (weighted_cfg) begin
				// Clip the weight to one, blend exactly, then round half up with floor.
				w = (node_mem[node].weight > WEIGHT_ONE) ? ONE_Q
					: longint'(node_mem[node].weight);
				blend_sum = mean_v * w + run * (ONE_Q - w) + 32768;
				run = blend_sum >>> 16;
			end else begin
				run = mean_v;
			end
			acc = sums[nd.feat] + (run - prev);
			if (acc > SUM_MAX)
				acc = SUM_MAX;
			else if (acc < SUM_MIN)
				acc = SUM_MIN;
			sums[nd.feat] = acc;
			prev = run;
			steps++;
		end

		r.value         = run[31:0];
		r.feature_index = 5'd0;
		r.is_prediction = 1'b1;
		r.last          = 1'b0;
		outputs_due.push_back(r);
		for (int f = 0; f < FEATURES; f++) begin
			r.value         = sums[f][31:0];
			r.feature_index = 5'(f);
			r.is_prediction = 1'b0;
			r.last          = (f == FEATURES - 1);
			outputs_due.push_back(r);
		end
	endfunction

	// Fill every field with noise; callers overwrite what matters for the op.
	function automatic item_t random_item(logic [1:0] kind);
		item_t it;

		it.op              = kind;
		it.address         = 10'($urandom);
		it.split_feature   = 5'($urandom);
		it.threshold       = $urandom;
		it.left_child      = 10'($urandom);
		it.right_child     = 10'($urandom);
		it.node_mean       = $urandom;
		it.node_weight     = 17'($urandom);
		it.is_leaf         = 1'($urandom);
		it.feature_value   = $urandom;
		it.feature_missing = 1'($urandom);
		return it;
	endfunction

	function automatic item_t make_node(logic [9:0] at, logic leaf, logic [4:0] feat,
			logic signed [31:0] thr, logic [9:0] left, logic [9:0] right,
			logic signed [31:0] mean, logic [16:0] weight);
		item_t it;

		it               = random_item(OP_NODE);
		it.address       = at;
		it.is_leaf       = leaf;
		it.split_feature = feat;
		it.threshold     = thr;
		it.left_child    = left;
		it.right_child   = right;
		it.node_mean     = mean;
		it.node_weight   = weight;
		return it;
	endfunction

	function automatic item_t make_feature(logic [9:0] at, logic signed [31:0] x,
			logic missing);
		item_t it;

		it                 = random_item(OP_FEATURE);
		it.address         = at;
		it.feature_value   = x;
		it.feature_missing = missing;
		return it;
	endfunction

	function automatic item_t random_feature(logic [4:0] f);
		item_t it;

		it = make_feature({5'd0, f}, $urandom, $urandom_range(0, 6) == 0);
		case ($urandom_range(0, 7))
			0: it.feature_value = Q_MAX;
			1: it.feature_value = Q_MIN;
			default: ;
		endcase
		return it;
	endfunction

	// Node with children drawn from the current tree so every walk stays on written nodes.
	function automatic item_t random_node(logic [9:0] at, logic [4:0] f);
		item_t it;

		it               = random_item(OP_NODE);
		it.address       = at;
		it.split_feature = f;
		it.is_leaf       = ($urandom_range(0, 99) < 30);
		it.left_child    = tree_slots[$urandom_range(0, tree_slots.size() - 1)];
		it.right_child   = tree_slots[$urandom_range(0, tree_slots.size() - 1)];
		// Land the cut right at the stored feature now and then to hit the tie.
		if (feature_known[f] && $urandom_range(0, 3) == 0)
			it.threshold = feat_mem[f].value + 32'($urandom_range(0, 2)) - 32'd1;
		case ($urandom_range(0, 7))
			0: it.node_mean = Q_MAX;
			1: it.node_mean = Q_MIN;
			default: ;
		endcase
		case ($urandom_range(0, 7))
			0: it.node_weight = 17'd0;
			1: it.node_weight = WEIGHT_ONE;
			2: it.node_weight = 17'($urandom_range(65537, 131071));
			default: it.node_weight = 17'($urandom_range(0, 65536));
		endcase
		return it;
	endfunction

	// Transfer one item on the item channel, then update the predictor.
	// Called on a clock edge; returns on the edge that accepted the item.
	task automatic send_item(item_t it);
		int unsigned gap;

		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 16);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
			if (gap != 0) begin
				item_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		item_valid      <= 1'b1;
		op              <= it.op;
		address         <= it.address;
		split_feature   <= it.split_feature;
		threshold       <= it.threshold;
		left_child      <= it.left_child;
		right_child     <= it.right_child;
		node_mean       <= it.node_mean;
		node_weight     <= it.node_weight;
		is_leaf         <= it.is_leaf;
		feature_value   <= it.feature_value;
		feature_missing <= it.feature_missing;
		@(posedge clk);
		while (item_stall)
			@(posedge clk);

		case (it.op)
			OP_NODE: begin
				node_mem[it.address].is_leaf   = it.is_leaf;
				node_mem[it.address].feat      = it.split_feature;
				node_mem[it.address].threshold = it.threshold;
				node_mem[it.address].left      = it.left_child;
				node_mem[it.address].right     = it.right_child;
				node_mem[it.address].mean      = it.node_mean;
				node_mem[it.address].weight    = it.node_weight;
				node_writes++;
				useful_items++;
			end
			OP_FEATURE: begin
				// Writes past the feature store are dropped.
				if (it.address < FEATURES) begin
					feat_mem[it.address[4:0]].value   = it.feature_value;
					feat_mem[it.address[4:0]].missing = it.feature_missing;
					feature_known[it.address[4:0]]    = 1'b1;
					feature_writes++;
					useful_items++;
				end
			end
			OP_EVAL: begin
				walk_tree();
				evaluations++;
				useful_items++;
			end
			default: ;
		endcase
	endtask

	// Hold the sender until every queued result has been transferred and the block is idle.
	task automatic wait_drained();
		item_valid <= 1'b0;
		burst_left = 0;
		while (outputs_due.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Write both registers back to back while the block is idle.
	task automatic set_config(logic weighted, logic [9:0] limit);
		wait_drained();
		cfg_write <= 1'b1;
		cfg_index <= REG_WEIGHTED;
		cfg_data  <= {9'd0, weighted};
		@(posedge clk);
		cfg_index <= REG_STEP_LIMIT;
		cfg_data  <= limit;
		@(posedge clk);
		cfg_write <= 1'b0;
		weighted_cfg = weighted;
		limit_cfg    = limit;
		config_writes += 2;
	endtask

	// Write one node of the current tree, loading its split feature first if needed.
	task automatic plant_node(logic [9:0] slot);
		logic [4:0] f;

		f = 5'($urandom);
		if (!feature_known[f])
			send_item(random_feature(f));
		send_item(random_node(slot, f));
	endtask

	// Root that is already a leaf, under the reset register values.
	task automatic test_root_leaf();
		send_item(make_feature(10'd0, 32'sh0001_0000, 1'b0));
		send_item(make_feature(10'd31, Q_MAX, 1'b0));
		send_item(make_feature(10'd1, Q_MIN, 1'b1));
		send_item(make_node(10'd0, 1'b1, 5'd0, 32'sd0, 10'd0, 10'd0, Q_MIN, 17'd0));
		send_item(random_item(OP_EVAL));
	endtask

	// Tie goes left, strictly greater goes right, a missing feature stops at the root.
	task automatic test_split_direction();
		send_item(make_node(10'd1, 1'b1, 5'd0, 32'sd0, 10'd0, 10'd0, Q_MIN, 17'h1FFFF));
		send_item(make_node(10'd2, 1'b1, 5'd0, 32'sd0, 10'd0, 10'd0, 32'sh0002_8000, 17'd0));
		// Root mean at the top and left leaf at the bottom saturates the sum low.
		send_item(make_node(10'd0, 1'b0, 5'd0, 32'sh0001_0000, 10'd1, 10'd2, Q_MAX,
			WEIGHT_ONE));
		send_item(random_item(OP_EVAL));
		send_item(make_node(10'd0, 1'b0, 5'd0, 32'sh0000_FFFF, 10'd1, 10'd2, Q_MAX,
			WEIGHT_ONE));
		send_item(random_item(OP_EVAL));
		send_item(make_node(10'd0, 1'b0, 5'd1, Q_MIN, 10'd1, 10'd2, Q_MAX, WEIGHT_ONE));
		send_item(random_item(OP_EVAL));
	endtask

	// Unused op and feature writes past the store must leave the stores alone.
	task automatic test_ignored_items();
		send_item(make_feature(10'd32, Q_MIN, 1'b1));
		send_item(make_feature(10'd1023, Q_MIN, 1'b1));
		send_item(random_item(OP_UNUSED));
		send_item(make_node(10'd0, 1'b0, 5'd0, 32'sd0, 10'd1, 10'd2, Q_MIN, 17'd0));
		send_item(random_item(OP_EVAL));
	endtask

	// Two nodes pointing at each other: the walk runs until the step limit.
	task automatic test_tree_loop();
		send_item(make_node(10'd1023, 1'b0, 5'd31, Q_MAX, 10'd0, 10'd512, Q_MAX, 17'h08000));
		send_item(make_node(10'd0, 1'b0, 5'd31, Q_MIN, 10'd0, 10'd1023, Q_MIN, 17'h1FFFF));
		send_item(random_item(OP_EVAL));
	endtask

	// Step limit and mode extremes on the loop tree.
	task automatic test_modes_and_limits();
		set_config(1'b1, 10'd1);
		send_item(random_item(OP_EVAL));
		set_config(1'b1, 10'd1000);
		send_item(random_item(OP_EVAL));
		set_config(1'b0, 10'd1);
		send_item(random_item(OP_EVAL));
		set_config(1'b1, 10'd2);
		send_item(random_item(OP_EVAL));
	endtask

	// Random small trees with loops, evaluated a few times each, with noise mixed in.
	task automatic test_random_trees();
		int unsigned start;
		int unsigned round;

		start = useful_items;
		round = 0;
		while (useful_items - start < RANDOM_ITEMS) begin
			if (round % 3 == 0) begin
				// Mostly short limits; the full limit only now and then.
				if (round % 9 == 6)
					set_config(1'($urandom), 10'd1000);
				else
					set_config(1'($urandom), 10'($urandom_range(1, 12)));
			end else if (round % 4 == 1) begin
				wait_drained();
			end
			tree_slots.delete();
			tree_slots.push_back(10'd0);
			repeat ($urandom_range(1, 6))
				tree_slots.push_back(10'($urandom_range(1, NODES - 1)));
			foreach (tree_slots[i])
				plant_node(tree_slots[i]);
			repeat ($urandom_range(1, 3)) begin
				case ($urandom_range(0, 7))
					0: send_item(random_item(OP_UNUSED));
					1: send_item(make_feature(10'($urandom_range(FEATURES, NODES - 1)),
						$urandom, 1'($urandom)));
					2, 3: send_item(random_feature(5'($urandom)));
					4: plant_node(tree_slots[$urandom_range(0, tree_slots.size() - 1)]);
					default: ;
				endcase
				send_item(random_item(OP_EVAL));
			end
			round++;
		end
	endtask

	// Receiver: switch between no stall, light stall and heavy stall in random stretches.
	int unsigned stall_stretch = 0;
	int unsigned stall_style   = 0;

	always @(posedge clk) begin
		if (stall_stretch == 0) begin
			stall_style   = $urandom_range(0, 2);
			stall_stretch = $urandom_range(20, 120);
		end else begin
			stall_stretch--;
		end
		case (stall_style)
			0: result_stall <= 1'b0;
			1: result_stall <= ($urandom_range(0, 9) < 3);
			default: result_stall <= ($urandom_range(0, 15) < 10);
		endcase
	end

	// Compare every transferred result with the oldest queued expectation.
	always @(posedge clk) begin : check_outputs
		result_t due;

		if (arst_n && result_valid && !result_stall) begin
			results_checked++;
			if (outputs_due.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result: value %h index %0d pred %b last %b",
						value, feature_index, is_prediction, last);
			end else begin
				due = outputs_due.pop_front();
				if (value !== due.value || feature_index !== due.feature_index ||
						is_prediction !== due.is_prediction || last !== due.last) begin
					mismatches++;
					if (mismatches <= 10)
						$display({"mismatch (exp/got): value %h/%h index %0d/%0d",
							" pred %b/%b last %b/%b"},
							due.value, value, due.feature_index, feature_index,
							due.is_prediction, is_prediction, due.last, last);
				end
			end
		end
	end

	initial begin
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_root_leaf();
		test_split_direction();
		test_ignored_items();
		test_tree_loop();
		test_modes_and_limits();
		test_random_trees();

		// Drain, then give a stray result time to show up.
		wait_drained();
		repeat (FEATURES + 8) @(posedge clk);

		$display("summary: %0d evaluations, %0d node writes, %0d feature writes",
			evaluations, node_writes, feature_writes);
		$display("summary: %0d register writes, %0d results checked over leaf, %s",
			config_writes, results_checked, "missing-feature and step-limit stops");
		if (mismatches == 0 && outputs_due.size() == 0) begin
			$display("tb: success");
		end else begin
			$display("tb: failure");
		end
		$finish;
	end

	initial begin
		#(TIMEOUT_NS);
		$display("tb: failure");
		$finish;
	end

endmodule
